### hdl/sfb_pkg.sv
// sfb_pkg: shared types and constants of the serial frame builder
// frame header codes, step numbering and the step decode struct
// no dependencies
`timescale 1ns / 1ps

package sfb_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned REM_W  = 5;
	localparam int unsigned STEP_W = 3;

	localparam logic [BYTE_W-1:0] HDR_SYNC      = 8'hAA;
	localparam logic [BYTE_W-1:0] HDR_ADDR      = 8'hFF;
	localparam logic [BYTE_W-1:0] HDR_FUNC_BASE = 8'hF0;
	localparam logic [BYTE_W-1:0] FUNC_MIN      = 8'd1;
	localparam logic [BYTE_W-1:0] FUNC_MAX      = 8'd10;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_PAYLOAD = 1'b1;

	// steps of a start item
	localparam logic [STEP_W-1:0] STEP_SYNC    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_ADDR    = 3'd1;
	localparam logic [STEP_W-1:0] STEP_FUNC    = 3'd2;
	localparam logic [STEP_W-1:0] STEP_LEN     = 3'd3;
	localparam logic [STEP_W-1:0] STEP_HDR_SUM = 3'd4;
	localparam logic [STEP_W-1:0] STEP_HDR_ADD = 3'd5;
	// steps of a payload item
	localparam logic [STEP_W-1:0] STEP_DATA    = 3'd0;
	localparam logic [STEP_W-1:0] STEP_PL_SUM  = 3'd1;
	localparam logic [STEP_W-1:0] STEP_PL_ADD  = 3'd2;

	typedef enum logic [2:0] {
		K_NONE = 3'd0,   // item gives no result in this step
		K_DATA = 3'd1,   // byte that enters the checks
		K_SUM  = 3'd2,   // sum check byte
		K_ADD  = 3'd3,   // add check byte, ends the frame
		K_REJ  = 3'd4    // rejected start item
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [BYTE_W-1:0] data;
		logic              last;      // final step of the item
		logic              clr;       // checks start from zero
		logic              set_open;  // header done, payload expected
		logic [REM_W-1:0]  new_rem;
		logic              dec_rem;   // one payload byte consumed
	} step_dec_t;

endpackage

### hdl/sfb_step.sv
// sfb_step: decodes what the held item emits at its current step
// depends on sfb_pkg
`timescale 1ns / 1ps

module sfb_step #(
	parameter int unsigned MAX_PAYLOAD = 20
) (
	input  logic                                req_type,
	input  logic [sfb_pkg::BYTE_W-1:0]          function_id,
	input  logic [sfb_pkg::BYTE_W-1:0]          frame_length,
	input  logic [sfb_pkg::BYTE_W-1:0]          payload_byte,
	input  logic [sfb_pkg::STEP_W-1:0]          step,
	input  logic                                frame_open,
	input  logic [sfb_pkg::REM_W-1:0]           bytes_remaining,
	output sfb_pkg::step_dec_t                  dec
);
	import sfb_pkg::*;

	localparam logic [BYTE_W-1:0] MAX_LEN = BYTE_W'(MAX_PAYLOAD);

	logic [BYTE_W-1:0] len_c;
	logic              func_ok;

	assign len_c   = (frame_length > MAX_LEN) ? MAX_LEN : frame_length;
	assign func_ok = (function_id >= FUNC_MIN) && (function_id <= FUNC_MAX);

	always_comb begin
		dec          = '0;
		dec.kind     = K_NONE;
		dec.new_rem  = len_c[REM_W-1:0];
		dec.last     = 1'b1;
		if (req_type == REQ_START) begin
			if (!func_ok) begin
				dec.kind = K_REJ;
			end else begin
				unique case (step)
					STEP_SYNC: begin
						dec.kind = K_DATA;
						dec.data = HDR_SYNC;
						dec.clr  = 1'b1;
						dec.last = 1'b0;
					end
					STEP_ADDR: begin
						dec.kind = K_DATA;
						dec.data = HDR_ADDR;
						dec.last = 1'b0;
					end
					STEP_FUNC: begin
						dec.kind = K_DATA;
						dec.data = HDR_FUNC_BASE | function_id;
						dec.last = 1'b0;
					end
					STEP_LEN: begin
						dec.kind     = K_DATA;
						dec.data     = len_c;
						dec.set_open = (len_c != '0);
						dec.last     = (len_c != '0);
					end
					STEP_HDR_SUM: begin
						dec.kind = K_SUM;
						dec.last = 1'b0;
					end
					STEP_HDR_ADD: dec.kind = K_ADD;
					default:      dec.kind = K_NONE;
				endcase
			end
		end else begin
			unique case (step)
				STEP_DATA: begin
					if (frame_open && (bytes_remaining != '0)) begin
						dec.kind    = K_DATA;
						dec.data    = payload_byte;
						dec.dec_rem = 1'b1;
						dec.last    = (bytes_remaining != REM_W'(1));
					end
				end
				STEP_PL_SUM: begin
					dec.kind = K_SUM;
					dec.last = 1'b0;
				end
				STEP_PL_ADD: dec.kind = K_ADD;
				default:     dec.kind = K_NONE;
			endcase
		end
	end

endmodule

### hdl/sfb_out_reg.sv
// sfb_out_reg: result register of the frame builder with valid/stall handshake
// depends on sfb_pkg
`timescale 1ns / 1ps

module sfb_out_reg (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [sfb_pkg::BYTE_W-1:0]  load_byte,
	input  logic                        load_end,
	input  logic                        load_rej,
	output logic                        free,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [sfb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                        frame_end,
	output logic                        rejected
);
	import sfb_pkg::*;

	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              end_q;
	logic              rej_q;

	// slot can take a new item when empty or being drained this cycle
	assign free = !valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			byte_q <= load_byte;
			end_q  <= load_end;
			rej_q  <= load_rej;
		end
	end

	assign result_valid = valid_q;
	assign tx_byte      = byte_q;
	assign frame_end    = end_q;
	assign rejected     = rej_q;

endmodule

### hdl/serial_frame_builder_sum_add_check_unit.sv
// serial frame builder: items wait in the item register, results in the result
// register; unless stalled, payload items and result bytes run at one per cycle,
// set by the single result register; a start item gives sync, address, function,
// length (plus header sum, add on empty payload); last payload byte adds sum, add
// reset clears the frame state, the checks and both handshake registers
// depends on sfb_pkg, sfb_step, sfb_out_reg
`timescale 1ns / 1ps

module serial_frame_builder_sum_add_check_unit #(
	parameter int unsigned MAX_PAYLOAD = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// item channel
	input  logic                        item_valid,
	output logic                        item_stall,
	input  logic                        req_type,
	input  logic [sfb_pkg::BYTE_W-1:0]  function_id,
	input  logic [sfb_pkg::BYTE_W-1:0]  frame_length,
	input  logic [sfb_pkg::BYTE_W-1:0]  payload_byte,
	// result channel
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic [sfb_pkg::BYTE_W-1:0]  tx_byte,
	output logic                        frame_end,
	output logic                        rejected
);
	import sfb_pkg::*;

	// held item
	logic              valid_s1;
	logic              req_s1;
	logic [BYTE_W-1:0] func_s1;
	logic [BYTE_W-1:0] len_s1;
	logic [BYTE_W-1:0] data_s1;
	logic [STEP_W-1:0] step_q;

	// frame state
	logic              open_q;
	logic [REM_W-1:0]  rem_q;
	logic [BYTE_W-1:0] sum_q;
	logic [BYTE_W-1:0] add_q;

	step_dec_t         dec;
	logic              out_free;
	logic              fire;
	logic              item_acc;
	logic [BYTE_W-1:0] sum_base;
	logic [BYTE_W-1:0] add_base;
	logic [BYTE_W-1:0] sum_n;
	logic [BYTE_W-1:0] add_n;
	logic [BYTE_W-1:0] res_byte;

	sfb_step #(
		.MAX_PAYLOAD (MAX_PAYLOAD)
	) u_step (
		.req_type        (req_s1),
		.function_id     (func_s1),
		.frame_length    (len_s1),
		.payload_byte    (data_s1),
		.step            (step_q),
		.frame_open      (open_q),
		.bytes_remaining (rem_q),
		.dec             (dec)
	);

	// a step that gives no result never waits on the result register
	assign fire = valid_s1 && ((dec.kind == K_NONE) || out_free);

	// take a new item once the held one finishes its last step
	assign item_stall = valid_s1 && !(fire && dec.last);
	assign item_acc   = item_valid && !item_stall;

	// running checks; a start item begins from cleared checks
	assign sum_base = dec.clr ? '0 : sum_q;
	assign add_base = dec.clr ? '0 : add_q;
	assign sum_n    = sum_base + dec.data;
	assign add_n    = add_base + sum_n;

	always_comb begin
		unique case (dec.kind)
			K_DATA:  res_byte = dec.data;
			K_SUM:   res_byte = sum_q;
			K_ADD:   res_byte = add_q;
			default: res_byte = '0;
		endcase
	end

	// item register and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			step_q   <= '0;
		end else if (item_acc) begin
			valid_s1 <= 1'b1;
			step_q   <= '0;
		end else if (fire) begin
			if (dec.last) begin
				valid_s1 <= 1'b0;
				step_q   <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_acc) begin
			req_s1  <= req_type;
			func_s1 <= function_id;
			len_s1  <= frame_length;
			data_s1 <= payload_byte;
		end
	end

	// frame state updates, one step per cycle whenever the held step fires
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			rem_q  <= '0;
			sum_q  <= '0;
			add_q  <= '0;
		end else if (fire) begin
			unique case (dec.kind)
				K_DATA: begin
					sum_q <= sum_n;
					add_q <= add_n;
					if (dec.clr) begin
						// new start abandons any open frame
						open_q <= 1'b0;
						rem_q  <= '0;
					end else if (dec.set_open) begin
						open_q <= 1'b1;
						rem_q  <= dec.new_rem;
					end else if (dec.dec_rem) begin
						rem_q <= rem_q - REM_W'(1);
					end
				end
				K_SUM: begin
					// sum check goes out, state kept for the add check
				end
				K_ADD, K_REJ: begin
					open_q <= 1'b0;
					rem_q  <= '0;
					sum_q  <= '0;
					add_q  <= '0;
				end
				default: begin
					// stray payload item is dropped
					open_q <= 1'b0;
				end
			endcase
		end
	end

	sfb_out_reg u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (fire && (dec.kind != K_NONE)),
		.load_byte    (res_byte),
		.load_end     (dec.kind == K_ADD),
		.load_rej     (dec.kind == K_REJ),
		.free         (out_free),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.tx_byte      (tx_byte),
		.frame_end    (frame_end),
		.rejected     (rejected)
	);

endmodule
